FILE: rtl/core/aes128_cbc_ecb_block_cipher_top_defines.svh
// Assertion macros for the top-level RTL of the AES-128 block cipher.
`ifndef AES128_CBC_ECB_BLOCK_CIPHER_TOP_DEFINES_SVH
`define AES128_CBC_ECB_BLOCK_CIPHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked at every rising clock edge, with the check held off during reset.
`define AES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising clock edge, during reset as well.
`define AES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AES_ASSERT(lbl, clk, rst_n, prop, msg)
`define AES_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/aes_pkg.sv
`default_nettype none

package aes_pkg;

    localparam int unsigned ROUND_COUNT_DEF = 10;
    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned CFG_AW  = 3;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_KEY_HIGH = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KEY_LOW  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_IV_HIGH  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_IV_LOW   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MODE     = 3'd4;

    // Mode codes: bit 0 selects decryption, bit 1 selects chaining.
    localparam logic [1:0] MODE_ECB_ENC = 2'd0;
    localparam logic [1:0] MODE_ECB_DEC = 2'd1;
    localparam logic [1:0] MODE_CBC_ENC = 2'd2;
    localparam logic [1:0] MODE_CBC_DEC = 2'd3;

    typedef logic [7:0] box_t [256];

    typedef struct packed {
        logic decrypt;
        logic last_round;
    } round_ctl_t;

    localparam box_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // The inverse table is derived from the forward one at elaboration.
    function automatic box_t build_inv_box();
        box_t r;
        for (int i = 0; i < 256; i++) begin
            r[SBOX[i]] = 8'(i);
        end
        return r;
    endfunction

    localparam box_t INV_SBOX = build_inv_box();

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Next round key from the current one and the round constant.
    function automatic logic [127:0] next_round_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aes_round.sv
`default_nettype none

module aes_round (
    input  wire logic [aes_pkg::BLOCK_W-1:0] state_in,
    input  wire logic [aes_pkg::BLOCK_W-1:0] round_key,
    input  wire aes_pkg::round_ctl_t         ctl,
    output logic      [aes_pkg::BLOCK_W-1:0] state_out
);
    import aes_pkg::*;

    logic [127:0] fwd_sub, inv_sub, fwd_mix, inv_mix, inv_add;

    // Byte i of the state sits at bits 127-8i down; row r, column c is byte r+4c.
    always_comb
    begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                fwd_sub[127-8*(r+4*c) -: 8] = SBOX[state_in[127-8*(r+4*((c+r)%4)) -: 8]];
                inv_sub[127-8*(r+4*((c+r)%4)) -: 8] = INV_SBOX[state_in[127-8*(r+4*c) -: 8]];
            end
        end
    end

    assign inv_add = inv_sub ^ round_key;

    always_comb
    begin
        logic [7:0] a0, a1, a2, a3;
        logic [7:0] b0, b1, b2, b3;
        logic [7:0] d2 [4];
        logic [7:0] d4 [4];
        logic [7:0] d8 [4];
        logic [7:0] e9 [4];
        logic [7:0] eb [4];
        logic [7:0] ed [4];
        logic [7:0] ee [4];
        logic [7:0] bb [4];
        for (int c = 0; c < 4; c++) begin
            a0 = fwd_sub[127-8*(4*c) -: 8];
            a1 = fwd_sub[127-8*(4*c+1) -: 8];
            a2 = fwd_sub[127-8*(4*c+2) -: 8];
            a3 = fwd_sub[127-8*(4*c+3) -: 8];
            fwd_mix[127-8*(4*c) -: 8]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            fwd_mix[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            fwd_mix[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            fwd_mix[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);

            b0 = inv_add[127-8*(4*c) -: 8];
            b1 = inv_add[127-8*(4*c+1) -: 8];
            b2 = inv_add[127-8*(4*c+2) -: 8];
            b3 = inv_add[127-8*(4*c+3) -: 8];
            bb[0] = b0;
            bb[1] = b1;
            bb[2] = b2;
            bb[3] = b3;
            for (int j = 0; j < 4; j++) begin
                d2[j] = xt(bb[j]);
                d4[j] = xt(d2[j]);
                d8[j] = xt(d4[j]);
                e9[j] = d8[j] ^ bb[j];
                eb[j] = d8[j] ^ d2[j] ^ bb[j];
                ed[j] = d8[j] ^ d4[j] ^ bb[j];
                ee[j] = d8[j] ^ d4[j] ^ d2[j];
            end
            inv_mix[127-8*(4*c) -: 8]   = ee[0] ^ eb[1] ^ ed[2] ^ e9[3];
            inv_mix[127-8*(4*c+1) -: 8] = e9[0] ^ ee[1] ^ eb[2] ^ ed[3];
            inv_mix[127-8*(4*c+2) -: 8] = ed[0] ^ e9[1] ^ ee[2] ^ eb[3];
            inv_mix[127-8*(4*c+3) -: 8] = eb[0] ^ ed[1] ^ e9[2] ^ ee[3];
        end
    end

    always_comb
    begin
        if (ctl.decrypt) begin
            state_out = ctl.last_round ? inv_add : inv_mix;
        end else begin
            state_out = (ctl.last_round ? fwd_sub : fwd_mix) ^ round_key;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/aes128_cbc_ecb_block_cipher_top.sv
// AES-128 block cipher (FIPS-197, no padding) in ECB or CBC mode, encrypt or
// decrypt. Each input transaction carries one 128-bit block and a message-start
// flag in tuser; each yields exactly one 128-bit output transaction. One block is
// processed at a time by the single round unit that runs one round per cycle:
// the block passes the idle state in which it is taken, key whitening, ten
// rounds and a result hand-off state before the next block is taken. The
// output register lets the next block be accepted while the previous result
// still waits. Round keys live in two 11-entry synchronous memories (upper and
// lower key halves); after reset and after every write of either key register
// they are rebuilt, one round key per cycle, and no block is accepted until
// that is done. Configuration writes are always taken and must only be issued
// while the core is idle. A message-start block in a CBC mode reloads the
// chaining block from the IV registers first.
`default_nettype none

module aes128_cbc_ecb_block_cipher_top #(
    parameter int unsigned ROUND_COUNT = aes_pkg::ROUND_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [aes_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [aes_pkg::HALF_W-1:0]    cfg_data,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [aes_pkg::BLOCK_W-1:0]   s_tdata,  // [63:0] block_high, [127:64] block_low
    input  wire logic                          s_tuser,  // [0] message_start
    // Output stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [aes_pkg::BLOCK_W-1:0]   m_tdata   // [63:0] result_high, [127:64] result_low
);
    import aes_pkg::*;

`include "aes128_cbc_ecb_block_cipher_top_defines.svh"

    localparam int unsigned RK_DEPTH = ROUND_COUNT + 1;
    localparam int unsigned RK_AW    = $clog2(RK_DEPTH);
    localparam int unsigned CNT_W    = $clog2(ROUND_COUNT + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ROUND_COUNT);

    typedef enum logic [2:0] {
        ST_KLOAD,
        ST_EXPAND,
        ST_IDLE,
        ST_WHITEN,
        ST_ROUND,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [HALF_W-1:0]    key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic [1:0]           mode_reg;
    logic [BLOCK_W-1:0]   chain_reg;
    logic [BLOCK_W-1:0]   blk_reg;
    logic [BLOCK_W-1:0]   st_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [BLOCK_W-1:0]   exp_key_reg;
    logic [7:0]           rcon_reg;
    logic [RK_AW-1:0]     exp_idx_reg;
    logic                 out_valid_reg;
    logic [BLOCK_W-1:0]   out_data_reg;

    // Round key memories: one entry per round key, upper and lower 64 bits.
    logic [HALF_W-1:0]    rk_hi_mem [RK_DEPTH];
    logic [HALF_W-1:0]    rk_lo_mem [RK_DEPTH];
    logic [HALF_W-1:0]    rk_hi_q, rk_lo_q;
    logic [RK_AW-1:0]     rd_addr;
    logic                 rk_we;

    logic                 cfg_fire, in_fire, key_write, done_fire;
    logic                 decrypt, chained;
    logic [BLOCK_W-1:0]   in_block, chain_use, round_key, round_out, result;
    logic [CNT_W-1:0]     key_step;
    round_ctl_t           round_ctl;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign key_write = cfg_fire && (cfg_addr == REG_KEY_HIGH || cfg_addr == REG_KEY_LOW);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // The finished block moves into the output register once that is free.
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || m_tready) && !key_write;

    assign decrypt  = mode_reg[0];
    assign chained  = mode_reg[1];
    // Byte 0 of the block is the most significant byte of the internal state.
    assign in_block  = {s_tdata[63:0], s_tdata[127:64]};
    assign chain_use = (chained && s_tuser) ? {iv_high_reg, iv_low_reg} : chain_reg;
    assign round_key = {rk_hi_q, rk_lo_q};
    assign rk_we     = (state_reg == ST_EXPAND);

    // Which round comes next for the key read issued this cycle.
    always_comb
    begin
        unique case (state_reg)
            ST_WHITEN: key_step = CNT_W'(1);
            ST_ROUND:  key_step = (cnt_reg == LAST_CNT) ? cnt_reg : cnt_reg + CNT_W'(1);
            default:   key_step = '0;
        endcase
    end

    // Decryption walks the key schedule backwards.
    assign rd_addr = decrypt ? RK_AW'(LAST_CNT - key_step) : RK_AW'(key_step);

    assign round_ctl.decrypt    = decrypt;
    assign round_ctl.last_round = (cnt_reg == LAST_CNT);

    aes_round u_round (
        .state_in  (st_reg),
        .round_key (round_key),
        .ctl       (round_ctl),
        .state_out (round_out)
    );

    // In CBC decryption the chaining block is applied after the cipher.
    assign result = (mode_reg == MODE_CBC_DEC) ? (st_reg ^ chain_reg) : st_reg;

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_hi_mem[exp_idx_reg] <= exp_key_reg[127:64];
            rk_lo_mem[exp_idx_reg] <= exp_key_reg[63:0];
        end
        rk_hi_q <= rk_hi_mem[rd_addr];
        rk_lo_q <= rk_lo_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_KLOAD;
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            iv_high_reg   <= '0;
            iv_low_reg    <= '0;
            mode_reg      <= MODE_ECB_ENC;
            chain_reg     <= '0;
            cnt_reg       <= '0;
            exp_idx_reg   <= '0;
            rcon_reg      <= 8'h01;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_addr)
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                    REG_IV_LOW:   iv_low_reg   <= cfg_data;
                    REG_MODE:     mode_reg     <= cfg_data[1:0];
                    default:      ;
                endcase
            end

            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (key_write)
            begin
                state_reg <= ST_KLOAD;
            end
            else
            begin
                unique case (state_reg)
                    ST_KLOAD:
                    begin
                        exp_key_reg <= {key_high_reg, key_low_reg};
                        exp_idx_reg <= '0;
                        rcon_reg    <= 8'h01;
                        state_reg   <= ST_EXPAND;
                    end
                    ST_EXPAND:
                    begin
                        exp_key_reg <= next_round_key(exp_key_reg, rcon_reg);
                        rcon_reg    <= xt(rcon_reg);
                        exp_idx_reg <= exp_idx_reg + RK_AW'(1);
                        if (exp_idx_reg == RK_AW'(ROUND_COUNT))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (in_fire)
                        begin
                            blk_reg   <= in_block;
                            st_reg    <= (mode_reg == MODE_CBC_ENC) ? (in_block ^ chain_use)
                                                                    : in_block;
                            chain_reg <= chain_use;
                            state_reg <= ST_WHITEN;
                        end
                    end
                    ST_WHITEN:
                    begin
                        st_reg    <= st_reg ^ round_key;
                        cnt_reg   <= CNT_W'(1);
                        state_reg <= ST_ROUND;
                    end
                    ST_ROUND:
                    begin
                        st_reg <= round_out;
                        if (cnt_reg == LAST_CNT)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                    ST_DONE:
                    begin
                        if (done_fire)
                        begin
                            out_data_reg <= {result[63:0], result[127:64]};
                            if (mode_reg == MODE_CBC_ENC)
                            begin
                                chain_reg <= result;
                            end
                            else if (mode_reg == MODE_CBC_DEC)
                            begin
                                chain_reg <= blk_reg;
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_KLOAD;
                endcase
            end
        end
    end

    // Only one block is in flight: an accepted block closes the input.
    `AES_ASSERT(a_one_block, clk, rst_n, in_fire |=> !s_tready, "second block accepted while busy")
    // A key write rebuilds the schedule before any block may enter.
    `AES_ASSERT(a_key_blocks, clk, rst_n, key_write |=> !s_tready, "block taken during key expansion")
    // A result appears only out of the hand-off state.
    `AES_ASSERT_ALWAYS(a_out_src, clk, $rose(m_tvalid) |-> $past(state_reg == ST_DONE), "stray result")

endmodule

`default_nettype wire
